// ===== hw/rtl/mis_pkg.sv =====
// Package with the shared types and constants of the merge-insertion sorter.
`timescale 1ns / 1ps
package mis_pkg;
  localparam int MaxItemsDefault = 64;

  typedef struct packed {
    logic [31:0] value;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sorted_value;
    logic        last_result;
    logic        overflowed;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_PAIR_RD0,
    ST_PAIR_RD1,
    ST_PAIR_WR,
    ST_SORT_INIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_SHIFT,
    ST_SORT_PUT,
    ST_CHAIN_LOW,
    ST_CHAIN_HIGH,
    ST_INS_NEXT,
    ST_INS_FETCH,
    ST_INS_SCAN,
    ST_INS_CMP,
    ST_INS_SHIFT_RD,
    ST_INS_SHIFT_WR,
    ST_INS_PUT,
    ST_LEFT,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;
endpackage

// ===== hw/rtl/merge_insertion_sorter.sv =====
// Top level of the merge-insertion sorter: loads values, sorts them and emits them ascending.
`timescale 1ns / 1ps
// Usage: drive value and last_item with start while busy is low; each accepted
// item is stored in the item memory. An item with last_item set (accepted or
// dropped when the store is full) starts the sort, and busy stays high until
// every sorted value has been emitted. Results appear on result with done high
// for exactly one cycle each, ascending, with last_result on the final one and
// overflowed set on every result of a set that lost items past MAX_ITEMS.
// The receiver cannot stall; results are simply presented once.
// Loading takes one item per cycle while busy is low. The sort uses 32-bit
// comparators and single-port memories for items, pairs and the chain: pairing
// reads both items of a pair and writes it ordered, and the stable pair sort and
// every chain insertion move or scan one entry at a time. Each insertion scans
// from the head of the chain, so the work grows with the square of N for a set
// of N values whatever its order. Emission reads each value, then presents it.
// Reset clears the count, the overflow mark and the sequencer; the stores
// hold whatever they held and are always written before they are read.
module merge_insertion_sorter #(
  parameter int MAX_ITEMS = mis_pkg::MaxItemsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mis_pkg::in_item_t  item,
  output logic               busy,
  output logic               done,
  output mis_pkg::out_item_t result
);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int PD = (MAX_ITEMS / 2 > 1) ? MAX_ITEMS / 2 : 2;
  localparam int PW = $clog2(PD);
  localparam int CW = IW + 1;

  logic [31:0] item_mem [MAX_ITEMS];
  logic [63:0] pair_mem [PD];
  logic [31:0] chain_mem [MAX_ITEMS];

  mis_pkg::state_t state, state_next;
  logic [CW-1:0] item_count;
  logic overflow_flag;
  logic [CW-1:0] p, len, i, j, k, hi, prev, pos;
  logic [3:0] idx;
  logic odd;
  logic [31:0] a, x, leftover_value, crd;
  logic [63:0] cur, prd;

  logic load_acc;
  assign busy = (state != mis_pkg::ST_LOAD);
  assign load_acc = start && !busy;

  logic [CW:0] nxt_full;
  assign nxt_full = (CW + 1)'(1) << idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mis_pkg::ST_LOAD;
      item_count <= '0;
      overflow_flag <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        mis_pkg::ST_LOAD: begin
          if (load_acc) begin
            if (item_count < CW'(MAX_ITEMS)) begin
              item_mem[item_count[IW-1:0]] <= item.value;
              item_count <= item_count + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
            odd <= (item_count < CW'(MAX_ITEMS)) ? ~item_count[0] : item_count[0];
            p <= ((item_count < CW'(MAX_ITEMS)) ? item_count + 1'b1 : item_count) >> 1;
            i <= '0;
          end
        end
        mis_pkg::ST_PAIR_RD0: begin
          if (odd && 32'(i) == 32'(p))
            leftover_value <= item_mem[IW'({i, 1'b0})];
          else
            a <= item_mem[IW'({i, 1'b0})];
        end
        mis_pkg::ST_PAIR_RD1: x <= item_mem[IW'({i, 1'b1})];
        mis_pkg::ST_PAIR_WR: begin
          pair_mem[PW'(i)] <= (a > x) ? {a, x} : {x, a};
          i <= i + 1'b1;
        end
        mis_pkg::ST_SORT_INIT: i <= CW'(1);
        mis_pkg::ST_SORT_RD: begin
          cur <= pair_mem[PW'(i)];
          j <= i;
        end
        mis_pkg::ST_SORT_CMP: prd <= pair_mem[PW'(j - 1'b1)];
        mis_pkg::ST_SORT_SHIFT: begin
          if (prd[63:32] > cur[63:32]) begin
            pair_mem[PW'(j)] <= prd;
            j <= j - 1'b1;
          end
        end
        mis_pkg::ST_SORT_PUT: begin
          pair_mem[PW'(j)] <= cur;
          i <= i + 1'b1;
        end
        mis_pkg::ST_CHAIN_LOW: begin
          prd <= pair_mem['0];
          len <= '0;
          i <= '0;
        end
        mis_pkg::ST_CHAIN_HIGH: begin
          if (len == '0) begin
            chain_mem['0] <= prd[31:0];
            len <= CW'(1);
          end else begin
            chain_mem[IW'(len)] <= prd[63:32];
            len <= len + 1'b1;
            i <= i + 1'b1;
          end
          if (len != '0 && i + 1'b1 < p) prd <= pair_mem[PW'(i + 1'b1)];
          hi <= (p < CW'(3)) ? p : CW'(3);
          prev <= CW'(1);
          idx <= 4'd3;
          k <= (p < CW'(3)) ? p : CW'(3);
        end
        mis_pkg::ST_INS_NEXT: begin
          if (k <= prev && hi < p) begin
            prev <= hi;
            hi <= (nxt_full - (CW + 1)'(hi) > (CW + 1)'(p)) ? p
                  : CW'(nxt_full - (CW + 1)'(hi));
            k <= (nxt_full - (CW + 1)'(hi) > (CW + 1)'(p)) ? p
                 : CW'(nxt_full - (CW + 1)'(hi));
            idx <= idx + 1'b1;
          end
        end
        mis_pkg::ST_INS_FETCH: begin
          x <= pair_mem[PW'(k - 1'b1)][31:0];
          pos <= '0;
        end
        mis_pkg::ST_LEFT: begin
          x <= leftover_value;
          pos <= '0;
          odd <= 1'b0;
          k <= '0;
        end
        mis_pkg::ST_INS_SCAN: crd <= chain_mem[IW'(pos)];
        mis_pkg::ST_INS_CMP: begin
          if (crd < x) pos <= pos + 1'b1;
          else j <= len;
        end
        mis_pkg::ST_INS_SHIFT_RD: crd <= chain_mem[IW'(j - 1'b1)];
        mis_pkg::ST_INS_SHIFT_WR: begin
          chain_mem[IW'(j)] <= crd;
          j <= j - 1'b1;
        end
        mis_pkg::ST_INS_PUT: begin
          chain_mem[IW'(pos)] <= x;
          len <= len + 1'b1;
          if (k != '0) k <= k - 1'b1;
        end
        mis_pkg::ST_EMIT_RD: begin
          if (i == CW'(MAX_ITEMS) || state_next == mis_pkg::ST_EMIT_RD) i <= '0;
          crd <= chain_mem[IW'(k)];
        end
        mis_pkg::ST_EMIT: begin
          done <= 1'b1;
          result.sorted_value <= crd;
          result.last_result <= (k + 1'b1 == len);
          result.overflowed <= overflow_flag;
          k <= k + 1'b1;
          if (k + 1'b1 == len) begin
            item_count <= '0;
            overflow_flag <= 1'b0;
          end
        end
        default: ;
      endcase
      if (state_next == mis_pkg::ST_EMIT_RD && state != mis_pkg::ST_EMIT_RD
          && state != mis_pkg::ST_EMIT)
        k <= '0;
      if (state == mis_pkg::ST_LOAD && load_acc && item.last_item) begin
        if (((item_count < CW'(MAX_ITEMS)) ? item_count + 1'b1 : item_count) == CW'(1))
          len <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mis_pkg::ST_LOAD:
        if (load_acc && item.last_item) begin
          if (((item_count < CW'(MAX_ITEMS)) ? item_count + 1'b1 : item_count) == '0)
            state_next = mis_pkg::ST_LOAD;
          else
            state_next = mis_pkg::ST_PAIR_RD0;
        end
      mis_pkg::ST_PAIR_RD0:
        if (i == p) begin
          if (p == '0) state_next = mis_pkg::ST_LEFT;
          else state_next = mis_pkg::ST_SORT_INIT;
        end else state_next = mis_pkg::ST_PAIR_RD1;
      mis_pkg::ST_PAIR_RD1: state_next = mis_pkg::ST_PAIR_WR;
      mis_pkg::ST_PAIR_WR: state_next = mis_pkg::ST_PAIR_RD0;
      mis_pkg::ST_SORT_INIT: state_next = mis_pkg::ST_SORT_RD;
      mis_pkg::ST_SORT_RD:
        state_next = (i < p) ? mis_pkg::ST_SORT_CMP : mis_pkg::ST_CHAIN_LOW;
      mis_pkg::ST_SORT_CMP:
        state_next = (j == '0) ? mis_pkg::ST_SORT_PUT : mis_pkg::ST_SORT_SHIFT;
      mis_pkg::ST_SORT_SHIFT:
        state_next = (prd[63:32] > cur[63:32]) ? mis_pkg::ST_SORT_CMP
                     : mis_pkg::ST_SORT_PUT;
      mis_pkg::ST_SORT_PUT: state_next = mis_pkg::ST_SORT_RD;
      mis_pkg::ST_CHAIN_LOW: state_next = mis_pkg::ST_CHAIN_HIGH;
      mis_pkg::ST_CHAIN_HIGH:
        if (len != '0 && i + 1'b1 >= p) state_next = mis_pkg::ST_INS_NEXT;
      mis_pkg::ST_INS_NEXT:
        if (k > prev) state_next = mis_pkg::ST_INS_FETCH;
        else if (hi >= p) state_next = odd ? mis_pkg::ST_LEFT : mis_pkg::ST_EMIT_RD;
      mis_pkg::ST_INS_FETCH: state_next = mis_pkg::ST_INS_SCAN;
      mis_pkg::ST_LEFT: state_next = mis_pkg::ST_INS_SCAN;
      mis_pkg::ST_INS_SCAN:
        state_next = (pos < len) ? mis_pkg::ST_INS_CMP : mis_pkg::ST_INS_PUT;
      mis_pkg::ST_INS_CMP:
        state_next = (crd < x) ? mis_pkg::ST_INS_SCAN
                     : ((len > pos) ? mis_pkg::ST_INS_SHIFT_RD : mis_pkg::ST_INS_PUT);
      mis_pkg::ST_INS_SHIFT_RD: state_next = mis_pkg::ST_INS_SHIFT_WR;
      mis_pkg::ST_INS_SHIFT_WR:
        state_next = (j - 1'b1 > pos) ? mis_pkg::ST_INS_SHIFT_RD : mis_pkg::ST_INS_PUT;
      mis_pkg::ST_INS_PUT:
        state_next = odd || k != '0 ? mis_pkg::ST_INS_NEXT : mis_pkg::ST_EMIT_RD;
      mis_pkg::ST_EMIT_RD: state_next = mis_pkg::ST_EMIT;
      mis_pkg::ST_EMIT:
        state_next = (k + 1'b1 == len) ? mis_pkg::ST_LOAD : mis_pkg::ST_EMIT_RD;
      default: state_next = mis_pkg::ST_LOAD;
    endcase
  end
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the merge-insertion sorter with its own sort predictor.
`timescale 1ns / 1ps
module tb_top;
  localparam int Depth = mis_pkg::MaxItemsDefault;
  localparam int WatchLimit = 200000;

  class sorted_set_board;
    logic [31:0]        held_values[$];
    bit                 dropped;
    mis_pkg::out_item_t pending[$];
    int                 failures;
    int                 results_seen;

    function void place(ref logic [31:0] chain[$], input logic [31:0] x);
      int pos;
      pos = 0;
      while (pos < chain.size() && chain[pos] < x) pos++;
      chain.insert(pos, x);
    endfunction

    function void note_item(mis_pkg::in_item_t it);
      logic [31:0] chain[$];
      logic [63:0] pairs[$];
      logic [63:0] cur;
      logic [31:0] a, b, spare;
      int          n, p, j, hi, prev, idx, nxt;
      bit          odd;
      mis_pkg::out_item_t r;
      if (held_values.size() < Depth) held_values.insert(held_values.size(), it.value);
      else dropped = 1;
      if (!it.last_item) return;
      n = held_values.size();
      if (n == 0) return;
      odd = n[0];
      spare = held_values[n - 1];
      p = n / 2;
      for (int i = 0; i < p; i++) begin
        a = held_values[2 * i];
        b = held_values[2 * i + 1];
        cur = (a > b) ? {a, b} : {b, a};
        pairs.insert(pairs.size(), cur);
      end
      for (int i = 1; i < p; i++) begin
        cur = pairs[i];
        j = i;
        while (j > 0 && pairs[j - 1][63:32] > cur[63:32]) begin
          pairs[j] = pairs[j - 1];
          j--;
        end
        pairs[j] = cur;
      end
      if (p > 0) begin
        chain.insert(chain.size(), pairs[0][31:0]);
        for (int i = 0; i < p; i++) chain.insert(chain.size(), pairs[i][63:32]);
        prev = 1;
        idx = 3;
        hi = (p < 3) ? p : 3;
        forever begin
          for (int i = hi; i > prev; i--) place(chain, pairs[i - 1][31:0]);
          if (hi >= p) break;
          nxt = (1 << idx) - hi;
          prev = hi;
          hi = (nxt > p) ? p : nxt;
          idx++;
        end
      end
      if (odd) place(chain, spare);
      foreach (chain[k]) begin
        r.sorted_value = chain[k];
        r.last_result = (k == chain.size() - 1);
        r.overflowed = dropped;
        pending.insert(pending.size(), r);
      end
      held_values.delete();
      dropped = 0;
    endfunction

    function void check_result(mis_pkg::out_item_t got);
      mis_pkg::out_item_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.sorted_value !== want.sorted_value || got.last_result !== want.last_result ||
          got.overflowed !== want.overflowed) begin
        $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                 want.sorted_value, want.last_result, want.overflowed,
                 got.sorted_value, got.last_result, got.overflowed);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  mis_pkg::in_item_t  item = '0;
  logic               busy, done;
  mis_pkg::out_item_t result;

  sorted_set_board board = new();
  int  idle_cycles;
  bit  steady;
  int  items_sent, sets_sent;

  always #4 clk = ~clk;

  merge_insertion_sorter uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [31:0] v, bit last);
    while (!steady && $urandom_range(99) < 25) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    item <= '{value: v, last_item: last};
    do @(posedge clk); while (busy);
    board.note_item('{value: v, last_item: last});
    items_sent++;
    if (last) sets_sent++;
  endtask

  task automatic send_set(int n, int kind);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = $urandom();
        1: v = 32'(i);
        2: v = 32'(n - i);
        3: v = $urandom_range(3);
        default: v = (i[0]) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      send_item(v, i == n - 1);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(32'hFFFF_FFFF, 1);
    send_item(32'h0, 1);
    send_set(2, 2);
    send_set(3, 4);
    send_set(5, 0);
    send_set(6, 3);
    drain();
    for (int i = 0; i < 66; i++) send_item($urandom(), i == 65);
    drain();
    steady = 1;
    while (items_sent < 120) send_set($urandom_range(1, 12), $urandom_range(4));
    steady = 0;
    send_set(Depth, 0);
    send_set(Depth, 2);
    while (items_sent < 320) send_set($urandom_range(1, 16), $urandom_range(4));
    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d items in %0d sets, checked %0d sorted results.",
             items_sent, sets_sent, board.results_seen);
    if (board.failures == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
